// File: hw/rtl/mm2h_pkg.sv
// ----------------------------------------------------------------------------
// mm2h_pkg
// Shared types and constants for the 32-bit MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mm2h_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TAIL = 2'd1;
    localparam logic [1:0] KIND_WORD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
        logic [31:0] start;
        logic        first;
        logic        last;
    } t_op;

endpackage

// File: hw/rtl/mm2h_front.sv
// ----------------------------------------------------------------------------
// mm2h_front
// Holds the seed register and classifies each input word as full word,
// tail or empty, masking tail bytes and forming the starting hash.
// ----------------------------------------------------------------------------
module mm2h_front
    import mm2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hash_seed_we,
    input  logic [31:0] i_hash_seed,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic [31:0] i_message_length,
    input  logic        i_first_item,
    input  logic        i_last_item,
    output t_op         o_op
);

    logic [31:0] r_seed;
    logic [31:0] tail_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_hash_seed_we) begin
            r_seed <= i_hash_seed;
        end
    end

    always_comb begin
        case (i_valid_bytes[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h00ff_ffff;
        endcase
    end

    always_comb begin
        o_op.start = r_seed ^ i_message_length;
        o_op.first = i_first_item;
        o_op.last  = i_last_item;
        if (i_valid_bytes[2]) begin
            o_op.kind = KIND_WORD;
            o_op.data = i_data_word;
        end else if (i_valid_bytes[1:0] != 2'd0) begin
            o_op.kind = KIND_TAIL;
            o_op.data = i_data_word & tail_mask;
        end else begin
            o_op.kind = KIND_NONE;
            o_op.data = i_data_word;
        end
    end

endmodule

// File: hw/rtl/mm2h_queue.sv
// ----------------------------------------------------------------------------
// mm2h_queue
// Small first-in first-out queue of classified words between the front
// and the back.
// ----------------------------------------------------------------------------
module mm2h_queue
    import mm2h_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

// File: hw/rtl/mm2h_back.sv
// ----------------------------------------------------------------------------
// mm2h_back
// Mixing sequencer: absorbs words and tails into the running hash, runs
// the final avalanche and holds the finished hash in the output register.
// ----------------------------------------------------------------------------
module mm2h_back
    import mm2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_empty,
    output logic        o_deq,
    output logic [31:0] o_digest,
    output logic        o_empty,
    input  logic        i_pop
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WORD2 = 2'd1;
    localparam logic [1:0] ST_FIN1  = 2'd2;
    localparam logic [1:0] ST_FIN2  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_k, n_k;
    logic [31:0] r_hm, n_hm;
    logic        r_last, n_last;
    logic [31:0] r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [31:0] h0;
    logic [31:0] mul_a_in, mul_a;
    logic [31:0] mul_b_in, mul_b;
    logic        out_free;

    assign h0       = i_op.first ? i_op.start : r_hash;
    assign mul_a_in = (i_op.kind == KIND_TAIL) ? (h0 ^ i_op.data) : h0;
    assign mul_a    = mul_a_in * MIX_MUL;
    assign mul_b    = mul_b_in * MIX_MUL;
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        case (r_state)
            ST_WORD2: mul_b_in = r_k ^ (r_k >> MIX_SHIFT);
            ST_FIN1:  mul_b_in = r_hash ^ (r_hash >> FIN_SHIFT_A);
            default:  mul_b_in = i_op.data;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_k         = r_k;
        n_hm        = r_hm;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_deq       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_deq  = 1'b1;
                    n_last = i_op.last;
                    unique case (i_op.kind)
                        KIND_WORD: begin
                            n_k     = mul_b;
                            n_hm    = mul_a;
                            n_state = ST_WORD2;
                        end
                        KIND_TAIL: begin
                            n_hash  = mul_a;
                            n_state = i_op.last ? ST_FIN1 : ST_IDLE;
                        end
                        default: begin
                            n_hash  = h0;
                            n_state = i_op.last ? ST_FIN1 : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WORD2: begin
                n_hash  = r_hm ^ mul_b;
                n_state = r_last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                n_k     = mul_b;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                if (out_free) begin
                    n_out       = r_k ^ (r_k >> FIN_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_hm   <= n_hm;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_digest = r_out;
    assign o_empty  = !r_out_valid;

    a_deq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |-> (r_state == ST_IDLE) && !i_empty)
        else $error("dequeue outside idle or from empty queue");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN2) && r_out_valid && !i_pop |=> (r_state == ST_FIN2))
        else $error("finished hash dropped while output stalled");

    a_word2_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORD2) |=> (r_state == ST_IDLE) || (r_state == ST_FIN1))
        else $error("word mix did not complete in one step");

endmodule

// File: hw/rtl/murmur2_hash_32.sv
// ----------------------------------------------------------------------------
// murmur2_hash_32
// Streaming 32-bit MurmurHash2 engine with a queue-style interface.
// ----------------------------------------------------------------------------
// Input channel: drive the word fields with push; a word is taken at a
// clock edge with push high and full low. first_item loads the running
// hash with seed xor message_length; last_item closes the message.
// Result channel: while empty is low, o_digest holds the finished hash
// of the oldest closed message; pop high at a clock edge takes it.
// Seed: i_hash_seed_we writes i_hash_seed; change it only while idle.
// Sequence: a full word passes the idle and word-mix states, a tail or
// empty item the idle state alone; a last item then runs the FIN1 and
// FIN2 avalanche steps. The sequencer takes a new item only in idle;
// the input queue takes words at one per cycle until it fills.
// Reset: seed and running hash clear to zero, input queue and result register empty.
// Stall: a waiting hash holds the sequencer in its last avalanche step;
// the input queue keeps accepting until full.
// ----------------------------------------------------------------------------
module murmur2_hash_32
    import mm2h_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hash_seed_we,
    input  logic [31:0] i_hash_seed,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic [31:0] i_message_length,
    input  logic        i_first_item,
    input  logic        i_last_item,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest
);

    t_op  front_op;
    t_op  queue_op;
    logic queue_empty;
    logic back_deq;

    mm2h_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_hash_seed_we   (i_hash_seed_we),
        .i_hash_seed      (i_hash_seed),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_message_length (i_message_length),
        .i_first_item     (i_first_item),
        .i_last_item      (i_last_item),
        .o_op             (front_op)
    );

    mm2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (back_deq),
        .o_op    (queue_op),
        .o_empty (queue_empty)
    );

    mm2h_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (queue_op),
        .i_empty  (queue_empty),
        .o_deq    (back_deq),
        .o_digest (o_digest),
        .o_empty  (empty),
        .i_pop    (pop)
    );

endmodule
